### design/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion shorthands, clocked on clock and disabled in reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define AST_SAME(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// antecedent implies consequent in the next cycle
`define AST_NEXT(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### design/atp_pkg.sv
// ----------------------------------------------------------------------------
// atp_pkg
// shared widths, coefficients and types of the polynomial atan2 pipeline
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package atp_pkg;

   // input and output formats
   localparam int COORD_WIDTH     = 16;
   localparam int ANGLE_FRAC_BITS = 13;
   localparam int OUT_WIDTH       = ANGLE_FRAC_BITS + 3;

   // magnitude of a coordinate needs one extra bit for the most negative code
   localparam int MAG_W = COORD_WIDTH + 1;

   // ratio is an unsigned Q.15 fraction, one divider stage per quotient bit
   localparam int RATIO_W    = 15;
   localparam int DIV_STAGES = RATIO_W;

   // polynomial coefficients in Q.16
   localparam logic [15:0] COEF1 = 16'd65232;
   localparam logic [14:0] COEF3 = 15'd18919;
   localparam logic [12:0] COEF5 = 13'd5199;

   // final product r*poly is 31 bits, shifted down to the angle fraction
   localparam int ATAN_PROD_W = RATIO_W + 16;
   localparam int ATAN_SHIFT  = ATAN_PROD_W - ANGLE_FRAC_BITS;

   // pi and pi/2 rounded to the angle fraction
   localparam logic [63:0] PI_Q62  = 64'hC90FDAA22168C235;
   localparam logic [63:0] PI_R    = (PI_Q62 + (64'd1 << (61 - ANGLE_FRAC_BITS)))
                                     >> (62 - ANGLE_FRAC_BITS);
   localparam logic [63:0] HPI_R   = (PI_Q62 + (64'd1 << (62 - ANGLE_FRAC_BITS)))
                                     >> (63 - ANGLE_FRAC_BITS);
   localparam logic signed [OUT_WIDTH-1:0] PI_Q      = PI_R[OUT_WIDTH-1:0];
   localparam logic signed [OUT_WIDTH-1:0] HALF_PI_Q = HPI_R[OUT_WIDTH-1:0];

   // prep stage, divider, four polynomial stages, output stage
   localparam int PIPE_DEPTH = 1 + DIV_STAGES + 4 + 1;
   localparam int CNT_W      = $clog2(PIPE_DEPTH + 1);

   // octant information that travels with each item
   typedef struct packed {
      logic zero;
      logic swap;
      logic x_neg;
      logic y_neg;
   } oct_type;

endpackage

`default_nettype wire

### design/atp_div.sv
// ----------------------------------------------------------------------------
// atp_div
// folds the vector into the first octant and divides min by max in a
// restoring divider pipeline, one quotient bit per stage
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module atp_div (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                in_valid,
   output logic                                     in_ready,
   input  wire logic signed [atp_pkg::COORD_WIDTH-1:0] x_coord,
   input  wire logic signed [atp_pkg::COORD_WIDTH-1:0] y_coord,
   output logic                                     out_valid,
   input  wire logic                                out_ready,
   output logic [atp_pkg::RATIO_W-1:0]              ratio,
   output atp_pkg::oct_type                         oct
);
   import atp_pkg::*;

   logic [DIV_STAGES:0]  v_ff;
   logic [DIV_STAGES:0]  rdy;
   logic [MAG_W-1:0]     rem_ff [0:DIV_STAGES];
   logic [MAG_W-1:0]     den_ff [0:DIV_STAGES];
   logic [RATIO_W-1:0]   q_ff   [0:DIV_STAGES];
   oct_type              oct_ff [0:DIV_STAGES];

   logic [MAG_W-1:0]     x_ext;
   logic [MAG_W-1:0]     y_ext;
   logic [MAG_W-1:0]     ax;
   logic [MAG_W-1:0]     ay;
   logic [MAG_W-1:0]     rem0_in;
   logic [MAG_W-1:0]     den0_in;
   oct_type              oct0_in;

   // absolute values and octant fold
   always_comb begin
      x_ext        = {x_coord[COORD_WIDTH-1], x_coord};
      y_ext        = {y_coord[COORD_WIDTH-1], y_coord};
      ax           = x_coord[COORD_WIDTH-1] ? (~x_ext + 1'b1) : x_ext;
      ay           = y_coord[COORD_WIDTH-1] ? (~y_ext + 1'b1) : y_ext;
      oct0_in.swap  = (ay > ax);
      oct0_in.zero  = (ax == '0) && (ay == '0);
      oct0_in.x_neg = x_coord[COORD_WIDTH-1];
      oct0_in.y_neg = y_coord[COORD_WIDTH-1];
      rem0_in      = oct0_in.swap ? ax : ay;
      den0_in      = oct0_in.swap ? ay : ax;
   end

   // prep stage
   assign rdy[0]   = !v_ff[0] || rdy[1];
   assign in_ready = rdy[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff[0] <= 1'b0;
      end else if (rdy[0]) begin
         v_ff[0] <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[0] && in_valid) begin
         rem_ff[0] <= rem0_in;
         den_ff[0] <= den0_in;
         q_ff[0]   <= '0;
         oct_ff[0] <= oct0_in;
      end
   end

   // divider stages; equal magnitudes give all ones, which is the 32767 cap
   for (genvar k = 1; k <= DIV_STAGES; k++) begin : g_div
      logic [MAG_W:0]   rem2;
      logic [MAG_W:0]   diff;
      logic             ge;
      logic [MAG_W-1:0] rem_in;
      logic [RATIO_W-1:0] q_in;

      always_comb begin
         rem2   = {rem_ff[k-1], 1'b0};
         diff   = rem2 - {1'b0, den_ff[k-1]};
         ge     = (rem2 >= {1'b0, den_ff[k-1]});
         rem_in = ge ? diff[MAG_W-1:0] : rem2[MAG_W-1:0];
         q_in   = {q_ff[k-1][RATIO_W-2:0], ge};
      end

      if (k == DIV_STAGES) begin : g_last
         assign rdy[k] = !v_ff[k] || out_ready;
      end else begin : g_mid
         assign rdy[k] = !v_ff[k] || rdy[k+1];
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k] <= 1'b0;
         end else if (rdy[k]) begin
            v_ff[k] <= v_ff[k-1];
         end
      end

      always_ff @(posedge clock) begin
         if (rdy[k] && v_ff[k-1]) begin
            rem_ff[k] <= rem_in;
            den_ff[k] <= den_ff[k-1];
            q_ff[k]   <= q_in;
            oct_ff[k] <= oct_ff[k-1];
         end
      end
   end

   assign out_valid = v_ff[DIV_STAGES];
   assign ratio     = q_ff[DIV_STAGES];
   assign oct       = oct_ff[DIV_STAGES];

   // final remainder is not needed downstream
   logic unused_rem;
   assign unused_rem = ^rem_ff[DIV_STAGES];

endmodule

`default_nettype wire

### design/atp_poly.sv
// ----------------------------------------------------------------------------
// atp_poly
// evaluates r*(c1 - r^2*(c3 - c5*r^2)) in four stages, one multiply each
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module atp_poly (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              in_valid,
   output logic                                   in_ready,
   input  wire logic [atp_pkg::RATIO_W-1:0]       ratio,
   input  wire atp_pkg::oct_type                  in_oct,
   output logic                                   out_valid,
   input  wire logic                              out_ready,
   output logic [atp_pkg::ANGLE_FRAC_BITS-1:0]    atan_mag,
   output atp_pkg::oct_type                       out_oct
);
   import atp_pkg::*;

   localparam int SQ_W  = 2 * RATIO_W;
   localparam int C5P_W = 13 + RATIO_W;

   logic [3:0]              v_ff;
   logic [3:0]              rdy;

   logic [RATIO_W-1:0]      r1_ff, r2_ff, r3_ff;
   logic [RATIO_W-1:0]      sq1_ff, sq2_ff;
   logic [14:0]             inner_ff;
   logic [15:0]             poly_ff;
   logic [ANGLE_FRAC_BITS-1:0] atan_ff;
   oct_type                 oct1_ff, oct2_ff, oct3_ff, oct4_ff;

   logic [SQ_W-1:0]         sq_prod;
   logic [C5P_W-1:0]        c5_prod;
   logic [14:0]             inner_in;
   logic [SQ_W-1:0]         mid_prod;
   logic [15:0]             poly_in;
   logic [ATAN_PROD_W-1:0]  atan_prod;

   // arithmetic of the four stages
   always_comb begin
      sq_prod   = SQ_W'(ratio) * SQ_W'(ratio);
      c5_prod   = C5P_W'(COEF5) * C5P_W'(sq1_ff);
      inner_in  = COEF3 - 15'(c5_prod[C5P_W-1:RATIO_W]);
      mid_prod  = SQ_W'(sq2_ff) * SQ_W'(inner_ff);
      poly_in   = COEF1 - 16'(mid_prod[SQ_W-1:RATIO_W]);
      atan_prod = ATAN_PROD_W'(r3_ff) * ATAN_PROD_W'(poly_ff);
   end

   // stall chain, each stage fills when it is empty or moving
   assign rdy[3]   = !v_ff[3] || out_ready;
   assign rdy[2]   = !v_ff[2] || rdy[3];
   assign rdy[1]   = !v_ff[1] || rdy[2];
   assign rdy[0]   = !v_ff[0] || rdy[1];
   assign in_ready = rdy[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (rdy[0]) v_ff[0] <= in_valid;
         if (rdy[1]) v_ff[1] <= v_ff[0];
         if (rdy[2]) v_ff[2] <= v_ff[1];
         if (rdy[3]) v_ff[3] <= v_ff[2];
      end
   end

   // square of the ratio
   always_ff @(posedge clock) begin
      if (rdy[0] && in_valid) begin
         r1_ff   <= ratio;
         sq1_ff  <= sq_prod[SQ_W-1:RATIO_W];
         oct1_ff <= in_oct;
      end
   end

   // inner term c3 - c5*r^2
   always_ff @(posedge clock) begin
      if (rdy[1] && v_ff[0]) begin
         r2_ff    <= r1_ff;
         sq2_ff   <= sq1_ff;
         inner_ff <= inner_in;
         oct2_ff  <= oct1_ff;
      end
   end

   // c1 - r^2*inner
   always_ff @(posedge clock) begin
      if (rdy[2] && v_ff[1]) begin
         r3_ff   <= r2_ff;
         poly_ff <= poly_in;
         oct3_ff <= oct2_ff;
      end
   end

   // r*poly scaled to the angle fraction
   always_ff @(posedge clock) begin
      if (rdy[3] && v_ff[2]) begin
         atan_ff <= atan_prod[ATAN_PROD_W-1:ATAN_SHIFT];
         oct4_ff <= oct3_ff;
      end
   end

   assign out_valid = v_ff[3];
   assign atan_mag  = atan_ff;
   assign out_oct   = oct4_ff;

   // low product bits fall away by truncation
   logic unused_bits;
   assign unused_bits = ^{sq_prod[RATIO_W-1:0], c5_prod[RATIO_W-1:0],
                          mid_prod[RATIO_W-1:0], atan_prod[ATAN_SHIFT-1:0]};

endmodule

`default_nettype wire

### design/atp_fold.sv
// ----------------------------------------------------------------------------
// atp_fold
// unfolds the first-octant angle into four quadrants, saturates to +-pi
// and holds the result item in the output register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module atp_fold (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              in_valid,
   output logic                                   in_ready,
   input  wire logic [atp_pkg::ANGLE_FRAC_BITS-1:0] atan_mag,
   input  wire atp_pkg::oct_type                  oct,
   output logic                                   out_valid,
   input  wire logic                              out_ready,
   output logic signed [atp_pkg::OUT_WIDTH-1:0]   angle
);
   import atp_pkg::*;

   localparam int A_W = OUT_WIDTH + 2;

   logic                         v_ff;
   logic signed [OUT_WIDTH-1:0]  angle_ff;

   logic signed [A_W-1:0]        t_ext;
   logic signed [A_W-1:0]        s_val;
   logic signed [A_W-1:0]        pi_ext;
   logic signed [A_W-1:0]        hpi_ext;
   logic signed [A_W-1:0]        a_val;
   logic signed [OUT_WIDTH-1:0]  angle_in;

   // quadrant correction and clamp
   always_comb begin
      t_ext   = signed'({{(A_W - ANGLE_FRAC_BITS){1'b0}}, atan_mag});
      pi_ext  = A_W'(PI_Q);
      hpi_ext = A_W'(HALF_PI_Q);
      s_val   = (oct.x_neg != oct.y_neg) ? -t_ext : t_ext;
      if (oct.zero) begin
         a_val = '0;
      end else if (!oct.swap) begin
         if (oct.x_neg) begin
            a_val = s_val + (oct.y_neg ? -pi_ext : pi_ext);
         end else begin
            a_val = s_val;
         end
      end else begin
         a_val = (oct.y_neg ? -hpi_ext : hpi_ext) - s_val;
      end
      if (a_val > pi_ext) begin
         angle_in = PI_Q;
      end else if (a_val < -pi_ext) begin
         angle_in = -PI_Q;
      end else begin
         angle_in = a_val[OUT_WIDTH-1:0];
      end
   end

   // output register
   assign in_ready = !v_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= 1'b0;
      end else if (in_ready) begin
         v_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         angle_ff <= angle_in;
      end
   end

   assign out_valid = v_ff;
   assign angle     = angle_ff;

endmodule

`default_nettype wire

### design/atan2_polynomial_approx.sv
// pipeline: 21 register stages from input acceptance to rsp_valid
//   (prep, 15 divider stages, 4 polynomial stages, output register)
// throughput: one item per cycle unless stalled; the restoring divider resolves
//   one quotient bit per stage, so the 15-bit ratio sets the pipeline length
// reset: synchronous, clears all stage valid bits; data registers keep contents
// ----------------------------------------------------------------------------
// atan2_polynomial_approx
// four-quadrant angle of a signed vector, Q3.13 radians, saturated to +-pi
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module atan2_polynomial_approx (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output logic                                      req_ready,
   input  wire logic signed [atp_pkg::COORD_WIDTH-1:0] req_x_coord,
   input  wire logic signed [atp_pkg::COORD_WIDTH-1:0] req_y_coord,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_ready,
   output logic signed [atp_pkg::OUT_WIDTH-1:0]      rsp_angle
);
   import atp_pkg::*;

   logic                        div_valid;
   logic                        div_ready;
   logic [RATIO_W-1:0]          div_ratio;
   oct_type                     div_oct;

   logic                        poly_valid;
   logic                        poly_ready;
   logic [ANGLE_FRAC_BITS-1:0]  poly_atan;
   oct_type                     poly_oct;

   // octant fold and ratio division
   atp_div u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .x_coord   (req_x_coord),
      .y_coord   (req_y_coord),
      .out_valid (div_valid),
      .out_ready (div_ready),
      .ratio     (div_ratio),
      .oct       (div_oct)
   );

   // odd polynomial on the ratio
   atp_poly u_poly (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (div_valid),
      .in_ready  (div_ready),
      .ratio     (div_ratio),
      .in_oct    (div_oct),
      .out_valid (poly_valid),
      .out_ready (poly_ready),
      .atan_mag  (poly_atan),
      .out_oct   (poly_oct)
   );

   // quadrant unfold and output register
   atp_fold u_fold (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (poly_valid),
      .in_ready  (poly_ready),
      .atan_mag  (poly_atan),
      .oct       (poly_oct),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .angle     (rsp_angle)
   );

endmodule

`default_nettype wire

### design/atp_checker.sv
// ----------------------------------------------------------------------------
// atp_checker
// port-level checks of the atan2 pipeline, bound to the top level
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module atp_checker (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   input  wire logic                            req_ready,
   input  wire logic                            rsp_valid,
   input  wire logic                            rsp_ready,
   input  wire logic signed [atp_pkg::OUT_WIDTH-1:0] rsp_angle
);
   import atp_pkg::*;

   logic [CNT_W-1:0] cnt_ff;
   logic [CNT_W-1:0] cnt_in;
   logic             req_fire;
   logic             rsp_fire;

   // items accepted but not yet delivered
   assign req_fire = req_valid && req_ready;
   assign rsp_fire = rsp_valid && rsp_ready;

   always_comb begin
      cnt_in = cnt_ff;
      if (req_fire && !rsp_fire) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (rsp_fire && !req_fire) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   // a result item needs an earlier input item
   `AST_SAME(a_rsp_has_req, rsp_valid, cnt_ff != '0, "result item without input item")

   // the pipeline never holds more items than it has stages
   `AST_SAME(a_depth, 1'b1, cnt_ff <= CNT_W'(PIPE_DEPTH), "more items in flight than stages")

   // angle stays within +-pi
   `AST_SAME(a_range, rsp_valid, (rsp_angle <= PI_Q) && (rsp_angle >= -PI_Q), "angle beyond pi")

   // a stalled result item holds
   `AST_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid, "result item dropped")
   `AST_NEXT(a_rsp_stable, rsp_valid && !rsp_ready, $stable(rsp_angle), "result item changed")

endmodule

bind atan2_polynomial_approx atp_checker u_atp_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_angle (rsp_angle)
);

`default_nettype wire

### tb/tb_atan2_polynomial_approx.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_atan2_polynomial_approx
// self-checking bench for the polynomial atan2 block: a short table of
// axis, diagonal and extreme vectors, then random vectors weighted toward
// small, equal, near-diagonal, axis-aligned, near-axis and extreme pairs;
// each result is compared with its table angle or a bit-exact fixed-point predictor
// ----------------------------------------------------------------------------
module tb_atan2_polynomial_approx;

   localparam int CW = atp_pkg::COORD_WIDTH;
   localparam int AW = atp_pkg::OUT_WIDTH;

   // angle constants in Q3.13
   localparam logic signed [AW-1:0] ANGLE_PI      = 16'sd25736;
   localparam logic signed [AW-1:0] ANGLE_HALF_PI = 16'sd12868;

   // odd polynomial coefficients in Q.16, and the final product shift
   localparam longint unsigned POLY_C1   = 65232;
   localparam longint unsigned POLY_C3   = 18919;
   localparam longint unsigned POLY_C5   = 5199;
   localparam int              ATAN_DROP = 31 - atp_pkg::ANGLE_FRAC_BITS;

   localparam int RANDOM_ITEMS  = 1250;
   localparam int MAX_REPORTS   = 10;
   localparam int DRAIN_LIMIT   = 100000;
   localparam int SETTLE_CYCLES = 40;

   typedef struct {
      logic signed [CW-1:0] x;
      logic signed [CW-1:0] y;
      bit                   known;
      logic signed [AW-1:0] angle;
   } vec_row_type;

   typedef struct {
      logic signed [CW-1:0] x;
      logic signed [CW-1:0] y;
      logic signed [AW-1:0] angle;
   } angle_exp_type;

   logic                 clock       = 1'b0;
   logic                 reset       = 1'b1;
   logic                 req_valid   = 1'b0;
   logic                 req_ready;
   logic signed [CW-1:0] req_x_coord = '0;
   logic signed [CW-1:0] req_y_coord = '0;
   logic                 rsp_valid;
   logic                 rsp_ready   = 1'b0;
   logic signed [AW-1:0] rsp_angle;

   angle_exp_type pending_angles[$];
   int         error_count = 0;
   int         burst_left  = 1;

   // directed vectors: axes and zero have obvious answers, the rest go to the predictor
   vec_row_type directed_rows [0:23] = '{
      '{16'sd0,      16'sd0,      1'b1, 16'sd0},
      '{16'sd1,      16'sd0,      1'b1, 16'sd0},
      '{16'sd32767,  16'sd0,      1'b1, 16'sd0},
      '{-16'sd1,     16'sd0,      1'b1, ANGLE_PI},
      '{16'sh8000,   16'sd0,      1'b1, ANGLE_PI},
      '{16'sd0,      16'sd1,      1'b1, ANGLE_HALF_PI},
      '{16'sd0,      16'sd32767,  1'b1, ANGLE_HALF_PI},
      '{16'sd0,      -16'sd1,     1'b1, -ANGLE_HALF_PI},
      '{16'sd0,      16'sh8000,   1'b1, -ANGLE_HALF_PI},
      '{16'sd32767,  16'sd32767,  1'b0, 16'sd0},
      '{16'sh8000,   16'sh8000,   1'b0, 16'sd0},
      '{16'sh8000,   16'sd32767,  1'b0, 16'sd0},
      '{16'sd32767,  16'sh8000,   1'b0, 16'sd0},
      '{16'sd1,      16'sd1,      1'b0, 16'sd0},
      '{-16'sd1,     16'sd1,      1'b0, 16'sd0},
      '{16'sd1,      -16'sd1,     1'b0, 16'sd0},
      '{-16'sd1,     -16'sd1,     1'b0, 16'sd0},
      '{16'sd32767,  16'sd1,      1'b0, 16'sd0},
      '{16'sh8000,   -16'sd1,     1'b0, 16'sd0},
      '{16'sd1,      16'sh8000,   1'b0, 16'sd0},
      '{16'sd12345,  -16'sd23456, 1'b0, 16'sd0},
      '{-16'sd20000, 16'sd7000,   1'b0, 16'sd0},
      '{16'sh8000,   -16'sd32767, 1'b0, 16'sd0},
      '{-16'sd1,     16'sh8000,   1'b0, 16'sd0}
   };

   atan2_polynomial_approx uut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_x_coord (req_x_coord),
      .req_y_coord (req_y_coord),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_angle   (rsp_angle)
   );

   // clock
   always #2 clock = ~clock;

   // bit-exact angle of a vector in Q3.13, saturated to +-pi
   function automatic logic signed [AW-1:0] predict_angle(input logic signed [CW-1:0] x,
                                                         input logic signed [CW-1:0] y);
      longint            xs, ys, t, a;
      longint unsigned   ax, ay, lo, hi, r, r2, inner, poly;
      bit                opposite, steep;
      xs = x;
      ys = y;
      ax = (xs < 0) ? -xs : xs;
      ay = (ys < 0) ? -ys : ys;
      if (ax == 0 && ay == 0) return '0;
      opposite = (xs < 0) != (ys < 0);
      steep    = ay > ax;
      lo       = steep ? ax : ay;
      hi       = steep ? ay : ax;
      // ratio in Q.15, a ratio of one saturates just below
      r = (lo << 15) / hi;
      if (r > 32767) r = 32767;
      r2    = (r * r) >> 15;
      inner = POLY_C3 - ((POLY_C5 * r2) >> 15);
      poly  = POLY_C1 - ((r2 * inner) >> 15);
      t     = longint'((r * poly) >> ATAN_DROP);
      if (opposite) t = -t;
      // fold back into the right quadrant
      if (!steep) begin
         a = t;
         if (xs < 0) a = a + ((ys >= 0) ? longint'(ANGLE_PI) : -longint'(ANGLE_PI));
      end else begin
         a = ((ys >= 0) ? longint'(ANGLE_HALF_PI) : -longint'(ANGLE_HALF_PI)) - t;
      end
      if (a > longint'(ANGLE_PI)) a = ANGLE_PI;
      if (a < -longint'(ANGLE_PI)) a = -longint'(ANGLE_PI);
      return a[AW-1:0];
   endfunction

   // signed coordinate from a magnitude 0..32768 and a sign
   function automatic logic signed [CW-1:0] signed_coord(input int mag, input bit neg);
      int v;
      v = neg ? -mag : mag;
      return v[CW-1:0];
   endfunction

   // random vector, weighted toward the corners of the behavior
   task automatic pick_vector(output logic signed [CW-1:0] x, output logic signed [CW-1:0] y);
      int m, n, kind;
      int extremes [6];
      extremes = '{-32768, -32767, -1, 0, 1, 32767};
      kind = $urandom_range(0, 9);
      case (kind)
         4: begin
            x = signed_coord($urandom_range(0, 8), 1'($urandom_range(0, 1)));
            y = signed_coord($urandom_range(0, 8), 1'($urandom_range(0, 1)));
         end
         5: begin
            m = $urandom_range(0, 32768);
            x = signed_coord(m, 1'($urandom_range(0, 1)));
            y = signed_coord(m, 1'($urandom_range(0, 1)));
         end
         6: begin
            m = $urandom_range(0, 32768);
            if ($urandom_range(0, 1)) begin
               x = signed_coord(m, 1'($urandom_range(0, 1)));
               y = '0;
            end else begin
               x = '0;
               y = signed_coord(m, 1'($urandom_range(0, 1)));
            end
         end
         7: begin
            x = signed_coord(extremes[$urandom_range(0, 5)], 1'b0);
            y = signed_coord(extremes[$urandom_range(0, 5)], 1'b0);
         end
         8: begin
            m = $urandom_range(0, 32768);
            n = m + $urandom_range(0, 6) - 3;
            if (n < 0) n = 0;
            if (n > 32768) n = 32768;
            x = signed_coord(m, 1'($urandom_range(0, 1)));
            y = signed_coord(n, 1'($urandom_range(0, 1)));
         end
         9: begin
            m = $urandom_range(16384, 32768);
            n = $urandom_range(0, 64);
            if ($urandom_range(0, 1)) begin
               x = signed_coord(m, 1'($urandom_range(0, 1)));
               y = signed_coord(n, 1'($urandom_range(0, 1)));
            end else begin
               x = signed_coord(n, 1'($urandom_range(0, 1)));
               y = signed_coord(m, 1'($urandom_range(0, 1)));
            end
         end
         default: begin
            x = CW'($urandom());
            y = CW'($urandom());
         end
      endcase
   endtask

   // offer one item, wait for acceptance, then maybe idle between bursts
   task automatic send_vector(input logic signed [CW-1:0] x, input logic signed [CW-1:0] y,
                              input bit known, input logic signed [AW-1:0] angle);
      angle_exp_type e;
      int gap;
      req_valid   <= 1'b1;
      req_x_coord <= x;
      req_y_coord <= y;
      do @(posedge clock); while (!req_ready);
      e.x     = x;
      e.y     = y;
      e.angle = known ? angle : predict_angle(x, y);
      pending_angles.push_back(e);
      burst_left--;
      if (burst_left == 0) begin
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                  : $urandom_range(1, 30);
         gap = $urandom_range(0, 12);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   task automatic note_error(input string msg);
      error_count++;
      if (error_count <= MAX_REPORTS) $display("%t: %s", $realtime, msg);
   endtask

   // receiver stalls: always ready, mostly ready, mostly stalled, or periodic
   int stall_left = 0;
   int stall_mode = 0;
   always @(posedge clock) begin
      if (stall_left == 0) begin
         stall_mode = $urandom_range(0, 3);
         stall_left = $urandom_range(8, 120);
      end
      stall_left--;
      case (stall_mode)
         0: rsp_ready <= 1'b1;
         1: rsp_ready <= ($urandom_range(0, 3) != 0);
         2: rsp_ready <= ($urandom_range(0, 3) == 0);
         default: rsp_ready <= (stall_left % 5 != 0);
      endcase
   end

   // result check against the oldest pending angle
   always @(posedge clock) begin
      angle_exp_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_angles.size() == 0) begin
            note_error($sformatf("angle %0d arrived with no item outstanding", rsp_angle));
         end else begin
            e = pending_angles.pop_front();
            if (rsp_angle !== e.angle)
               note_error($sformatf("x=%0d y=%0d: angle expected %0d, got %0d",
                                    e.x, e.y, e.angle, rsp_angle));
         end
      end
   end

   // stimulus and end of run
   initial begin
      logic signed [CW-1:0] rx, ry;
      int wait_cycles;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int i = 0; i < $size(directed_rows); i++)
         send_vector(directed_rows[i].x, directed_rows[i].y,
                     directed_rows[i].known, directed_rows[i].angle);

      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         // hold off once until the pipeline has fully drained
         if (i == RANDOM_ITEMS / 2) begin
            req_valid <= 1'b0;
            do @(posedge clock); while (pending_angles.size() != 0);
         end
         pick_vector(rx, ry);
         send_vector(rx, ry, 1'b0, '0);
      end
      req_valid <= 1'b0;

      // drain, then give the pipeline time to show any stray result
      wait_cycles = 0;
      while (pending_angles.size() != 0 && wait_cycles < DRAIN_LIMIT) begin
         @(posedge clock);
         wait_cycles++;
      end
      if (pending_angles.size() != 0)
         note_error($sformatf("%0d angles never arrived", pending_angles.size()));
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (error_count == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

   // watchdog
   initial begin
      #2000000;
      $display("FAILED: results differ");
      $finish;
   end

endmodule

### files.f
+incdir+design
design/atp_pkg.sv
design/atp_div.sv
design/atp_poly.sv
design/atp_fold.sv
design/atan2_polynomial_approx.sv
design/atp_checker.sv
tb/tb_atan2_polynomial_approx.sv
